// File: hw/rtl/mtp_pkg.sv
// ---------------------------------------------------------------------------
// mtp_pkg
// Shared types and constants of the meter telegram parser.
// ---------------------------------------------------------------------------
`default_nettype none

package mtp_pkg;

   localparam int LINE_MAX = 32;
   localparam int LEN_W    = $clog2(LINE_MAX + 1);
   localparam int IDX_W    = $clog2(LINE_MAX);

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   localparam int CKS_DIGITS = 4;
   localparam int CNT_W      = 3;

   localparam logic [2:0] KIND_START    = 3'd0;
   localparam logic [2:0] KIND_HEADER   = 3'd1;
   localparam logic [2:0] KIND_ID       = 3'd2;
   localparam logic [2:0] KIND_VALUE    = 3'd3;
   localparam logic [2:0] KIND_UNIT     = 3'd4;
   localparam logic [2:0] KIND_END      = 3'd6;
   localparam logic [2:0] KIND_OVERFLOW = 3'd7;

   typedef enum logic [3:0] {
      ST_WAIT,
      ST_HEADER,
      ST_BETWEEN,
      ST_REG,
      ST_CHECKSUM,
      ST_EMIT_START,
      ST_EMIT_HDR,
      ST_EMIT_OVF,
      ST_EMIT_ID,
      ST_EMIT_VAL,
      ST_EMIT_UNIT,
      ST_EMIT_END
   } ctrl_state_type;

   typedef enum logic [1:0] {
      RNG_HDR,
      RNG_ID,
      RNG_VAL,
      RNG_UNIT
   } range_type;

   typedef struct packed {
      logic       clear;
      logic       add;
      logic       ptr_load;
      logic       ptr_inc;
      range_type  load_sel;
      logic       cks_clear;
      logic       cks_shift;
      logic       emit;
      logic [2:0] kind;
      logic       last;
   } mtp_cmd_type;

   typedef struct packed {
      logic is_slash;
      logic is_bang;
      logic is_eol;
      logic is_hex;
      logic cks_full;
      logic ovf;
      logic line_ok;
      logic hdr_empty;
      logic val_nonempty;
      logic unit_nonempty;
      logic at_end;
      logic out_free;
   } mtp_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/mtp_datapath.sv
// ---------------------------------------------------------------------------
// mtp_datapath
// Line buffer, delimiter positions, checksum shifter and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module mtp_datapath
   import mtp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [7:0]     req_rx_byte,
   input  wire mtp_cmd_type    cmd,
   output mtp_status_type      status,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic [2:0]          rsp_kind,
   output logic [15:0]         rsp_payload,
   output logic                rsp_last_of_run
);

   logic [7:0]       store_ff [LINE_MAX];
   logic [LEN_W-1:0] len_ff, len_in, len_base;
   logic [IDX_W-1:0] open_ff, open_in, close_ff, close_in, star_ff, star_in;
   logic             open_v_ff, open_v_in, close_v_ff, close_v_in, star_v_ff, star_v_in;
   logic             ovf_ff, ovf_in;
   logic             open_v_base, close_v_base, star_v_base;
   logic [15:0]      cks_ff, cks_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   range_type        rng_ff, rng_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       kind_ff, kind_in;
   logic [15:0]      payload_ff;
   logic             last_ff, last_in;
   logic             wr_en;
   logic [3:0]       nibble;
   logic             hex_ok;
   logic [LEN_W-1:0] open_l, close_l, star_l, vend_l, rng_to, ptr_next;
   logic [7:0]       c;

   assign c = req_rx_byte;

   always_comb begin
      nibble = 4'd0;
      hex_ok = 1'b1;
      if (c >= 8'h30 && c <= 8'h39) begin
         nibble = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         nibble = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         nibble = 4'(c - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign open_l  = LEN_W'(open_ff);
   assign close_l = LEN_W'(close_ff);
   assign star_l  = LEN_W'(star_ff);
   assign vend_l  = star_v_ff ? star_l : close_l;

   always_comb begin
      case (rng_ff)
         RNG_HDR:  rng_to = len_ff;
         RNG_ID:   rng_to = open_l;
         RNG_VAL:  rng_to = vend_l;
         RNG_UNIT: rng_to = close_l;
         default:  rng_to = len_ff;
      endcase
   end

   assign ptr_next = LEN_W'(ptr_ff) + LEN_W'(1);

   assign status.is_slash      = (c == CHAR_SLASH);
   assign status.is_bang       = (c == CHAR_BANG);
   assign status.is_eol        = (c == CHAR_CR) || (c == CHAR_LF);
   assign status.is_hex        = hex_ok;
   assign status.cks_full      = (cnt_ff == CNT_W'(CKS_DIGITS - 1));
   assign status.ovf           = ovf_ff;
   assign status.line_ok       = open_v_ff && close_v_ff && (open_ff != '0) &&
                                 (open_ff <= close_ff) && (len_ff != '0) &&
                                 (close_l == len_ff - LEN_W'(1));
   assign status.hdr_empty     = (len_ff == '0);
   assign status.val_nonempty  = (open_l + LEN_W'(1)) < vend_l;
   assign status.unit_nonempty = star_v_ff && ((star_l + LEN_W'(1)) < close_l);
   assign status.at_end        = ptr_next >= rng_to;
   assign status.out_free      = !rsp_valid_ff || !rsp_stall;

   // line accumulation; clear and add together start a fresh line
   always_comb begin
      len_base     = cmd.clear ? '0 : len_ff;
      open_v_base  = cmd.clear ? 1'b0 : open_v_ff;
      close_v_base = cmd.clear ? 1'b0 : close_v_ff;
      star_v_base  = cmd.clear ? 1'b0 : star_v_ff;
      len_in       = len_base;
      open_v_in    = open_v_base;
      close_v_in   = close_v_base;
      star_v_in    = star_v_base;
      ovf_in       = cmd.clear ? 1'b0 : ovf_ff;
      open_in      = open_ff;
      close_in     = close_ff;
      star_in      = star_ff;
      wr_en        = 1'b0;
      if (cmd.add) begin
         if (len_base >= LEN_W'(LINE_MAX)) begin
            ovf_in = 1'b1;
         end else begin
            wr_en  = 1'b1;
            len_in = len_base + LEN_W'(1);
            if (c == CHAR_OPEN && !open_v_base) begin
               open_in   = len_base[IDX_W-1:0];
               open_v_in = 1'b1;
            end else if (c == CHAR_CLOSE && !close_v_base) begin
               close_in   = len_base[IDX_W-1:0];
               close_v_in = 1'b1;
            end else if (c == CHAR_STAR && open_v_base && !star_v_base) begin
               star_in   = len_base[IDX_W-1:0];
               star_v_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      cks_in = cks_ff;
      cnt_in = cnt_ff;
      if (cmd.cks_clear) begin
         cks_in = '0;
         cnt_in = '0;
      end else if (cmd.cks_shift) begin
         cks_in = {cks_ff[11:0], nibble};
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // the range being sequenced is latched with its start pointer
   always_comb begin
      ptr_in = ptr_ff;
      rng_in = rng_ff;
      if (cmd.ptr_load) begin
         rng_in = cmd.load_sel;
         case (cmd.load_sel)
            RNG_VAL:  ptr_in = open_ff + IDX_W'(1);
            RNG_UNIT: ptr_in = star_ff + IDX_W'(1);
            default:  ptr_in = '0;
         endcase
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      last_in      = last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = cmd.kind;
         last_in      = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[len_base[IDX_W-1:0]] <= c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         open_v_ff    <= 1'b0;
         close_v_ff   <= 1'b0;
         star_v_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         cks_ff       <= '0;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         open_v_ff    <= open_v_in;
         close_v_ff   <= close_v_in;
         star_v_ff    <= star_v_in;
         ovf_ff       <= ovf_in;
         cks_ff       <= cks_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      open_ff  <= open_in;
      close_ff <= close_in;
      star_ff  <= star_in;
      rng_ff   <= rng_in;
      kind_ff  <= kind_in;
      last_ff  <= last_in;
      if (cmd.emit) begin
         case (cmd.kind)
            KIND_HEADER, KIND_ID, KIND_VALUE, KIND_UNIT: begin
               payload_ff <= {8'h00, store_ff[ptr_ff]};
            end
            KIND_END: payload_ff <= cks_ff;
            default:  payload_ff <= '0;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_payload     = payload_ff;
   assign rsp_last_of_run = last_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(LINE_MAX))
      else $error("line length beyond buffer");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (len_ff == LEN_W'(LINE_MAX)))
      else $error("overflow flag without full buffer");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded over a pending transfer");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

`default_nettype wire

// File: hw/rtl/mtp_ctrl.sv
// ---------------------------------------------------------------------------
// mtp_ctrl
// Parse phase and result sequencing state machine.
// ---------------------------------------------------------------------------
`default_nettype none

module mtp_ctrl
   import mtp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire mtp_status_type status,
   output mtp_cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;
   logic           listen;
   logic           take;
   logic           free;

   assign listen = (state_ff == ST_WAIT) || (state_ff == ST_HEADER) ||
                   (state_ff == ST_BETWEEN) || (state_ff == ST_REG) ||
                   (state_ff == ST_CHECKSUM);
   assign take      = req_valid && listen;
   assign free      = status.out_free;
   assign req_stall = !listen;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_WAIT: begin
            if (take) begin
               state_in = status.is_slash ? ST_HEADER : ST_WAIT;
            end
         end
         ST_HEADER: begin
            if (take && status.is_eol) begin
               state_in = ST_EMIT_START;
            end
         end
         ST_BETWEEN: begin
            if (take) begin
               if (status.is_bang) begin
                  state_in = ST_CHECKSUM;
               end else if (!status.is_eol) begin
                  state_in = ST_REG;
               end
            end
         end
         ST_REG: begin
            if (take && status.is_eol) begin
               if (status.ovf) begin
                  state_in = ST_EMIT_OVF;
               end else if (status.line_ok) begin
                  state_in = ST_EMIT_ID;
               end else begin
                  state_in = ST_BETWEEN;
               end
            end
         end
         ST_CHECKSUM: begin
            if (take) begin
               if (!status.is_hex) begin
                  state_in = ST_WAIT;
               end else if (status.cks_full) begin
                  state_in = ST_EMIT_END;
               end
            end
         end
         ST_EMIT_START: begin
            if (free) begin
               if (status.ovf) begin
                  state_in = ST_EMIT_OVF;
               end else if (status.hdr_empty) begin
                  state_in = ST_BETWEEN;
               end else begin
                  state_in = ST_EMIT_HDR;
               end
            end
         end
         ST_EMIT_HDR: begin
            if (free && status.at_end) begin
               state_in = ST_BETWEEN;
            end
         end
         ST_EMIT_OVF: begin
            if (free) begin
               state_in = ST_BETWEEN;
            end
         end
         ST_EMIT_ID: begin
            if (free && status.at_end) begin
               if (status.val_nonempty) begin
                  state_in = ST_EMIT_VAL;
               end else if (status.unit_nonempty) begin
                  state_in = ST_EMIT_UNIT;
               end else begin
                  state_in = ST_BETWEEN;
               end
            end
         end
         ST_EMIT_VAL: begin
            if (free && status.at_end) begin
               state_in = status.unit_nonempty ? ST_EMIT_UNIT : ST_BETWEEN;
            end
         end
         ST_EMIT_UNIT: begin
            if (free && status.at_end) begin
               state_in = ST_BETWEEN;
            end
         end
         ST_EMIT_END: begin
            if (free) begin
               state_in = ST_WAIT;
            end
         end
         default: state_in = ST_WAIT;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.load_sel = RNG_HDR;
      cmd.kind     = KIND_START;
      case (state_ff)
         ST_WAIT: begin
            cmd.clear = take && status.is_slash;
         end
         ST_HEADER: begin
            cmd.add = take && !status.is_eol;
         end
         ST_BETWEEN: begin
            if (take) begin
               if (status.is_bang) begin
                  cmd.cks_clear = 1'b1;
               end else if (!status.is_eol) begin
                  cmd.clear = 1'b1;
                  cmd.add   = 1'b1;
               end
            end
         end
         ST_REG: begin
            if (take) begin
               if (!status.is_eol) begin
                  cmd.add = 1'b1;
               end else if (!status.ovf && status.line_ok) begin
                  cmd.ptr_load = 1'b1;
                  cmd.load_sel = RNG_ID;
               end else if (!status.ovf) begin
                  cmd.clear = 1'b1;
               end
            end
         end
         ST_CHECKSUM: begin
            cmd.cks_shift = take && status.is_hex;
         end
         ST_EMIT_START: begin
            if (free) begin
               cmd.emit     = 1'b1;
               cmd.kind     = KIND_START;
               cmd.last     = !status.ovf && status.hdr_empty;
               cmd.ptr_load = 1'b1;
               cmd.clear    = !status.ovf && status.hdr_empty;
            end
         end
         ST_EMIT_HDR: begin
            if (free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = KIND_HEADER;
               cmd.last    = status.at_end;
               cmd.ptr_inc = 1'b1;
               cmd.clear   = status.at_end;
            end
         end
         ST_EMIT_OVF: begin
            if (free) begin
               cmd.emit  = 1'b1;
               cmd.kind  = KIND_OVERFLOW;
               cmd.last  = 1'b1;
               cmd.clear = 1'b1;
            end
         end
         ST_EMIT_ID: begin
            if (free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = KIND_ID;
               cmd.last    = status.at_end && !status.val_nonempty && !status.unit_nonempty;
               cmd.ptr_inc = 1'b1;
               if (status.at_end) begin
                  if (status.val_nonempty) begin
                     cmd.ptr_load = 1'b1;
                     cmd.load_sel = RNG_VAL;
                  end else if (status.unit_nonempty) begin
                     cmd.ptr_load = 1'b1;
                     cmd.load_sel = RNG_UNIT;
                  end else begin
                     cmd.clear = 1'b1;
                  end
               end
            end
         end
         ST_EMIT_VAL: begin
            if (free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = KIND_VALUE;
               cmd.last    = status.at_end && !status.unit_nonempty;
               cmd.ptr_inc = 1'b1;
               if (status.at_end) begin
                  if (status.unit_nonempty) begin
                     cmd.ptr_load = 1'b1;
                     cmd.load_sel = RNG_UNIT;
                  end else begin
                     cmd.clear = 1'b1;
                  end
               end
            end
         end
         ST_EMIT_UNIT: begin
            if (free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = KIND_UNIT;
               cmd.last    = status.at_end;
               cmd.ptr_inc = 1'b1;
               cmd.clear   = status.at_end;
            end
         end
         ST_EMIT_END: begin
            if (free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_END;
               cmd.last = 1'b1;
            end
         end
         default: begin
            cmd.clear = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_take_while_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> req_stall)
      else $error("input transfer during result sequencing");

   a_clear_add_fresh: assert property (@(posedge clock) disable iff (reset)
      (cmd.add && cmd.clear) |-> (state_ff == ST_BETWEEN))
      else $error("fresh line started outside line gap");

   a_end_to_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_END && free) |=> (state_ff == ST_WAIT))
      else $error("frame end not followed by wait");

endmodule

`default_nettype wire

// File: hw/rtl/meter_telegram_parser_top.sv
// ---------------------------------------------------------------------------
// meter_telegram_parser_top
// Byte-serial smart meter telegram parser.
// ---------------------------------------------------------------------------
// A byte that causes no result is taken without a stall. A byte that ends
// a line keeps req_stall high while its results are sequenced out of the
// line buffer, one result per cycle the output register is free: a register
// line of 32 bytes gives at most 30 results, a header line up to 33. The
// output register lets the next byte enter while the last result of a run
// still waits for its transfer.
`default_nettype none

module meter_telegram_parser_top
   import mtp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [15:0]      rsp_payload,
   output logic             rsp_last_of_run
);

   mtp_cmd_type    cmd;
   mtp_status_type status;

   mtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mtp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_rx_byte     (req_rx_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_payload     (rsp_payload),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// File: verif/meter_telegram_parser_top_test.sv
// ---------------------------------------------------------------------------
// meter_telegram_parser_top_test
// Self-checking testbench of the byte-serial meter telegram parser.
// Telegram bytes are fed in one transfer at a time. A scoreboard tracks the
// frame, header, register-line and checksum phases and predicts every
// result: frame start, header bytes, id/value/unit bytes, frame end with
// the received checksum, and line overflow. Each result transfer is checked
// in order against that prediction. Valid and stall gaps are random on both
// sides, and one long receiver hold-off backs the parser up into its input.
// ---------------------------------------------------------------------------
`default_nettype none

module meter_telegram_parser_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mtp_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_ITEMS  = 150;
   localparam int HOLD_CYCLES   = 400;
   localparam int MAX_PRINTS    = 50;

   typedef enum {PH_IDLE, PH_HDR, PH_GAP, PH_LINE, PH_CKS} frame_phase_type;

   typedef struct {
      logic [2:0]  kind;
      logic [15:0] payload;
      logic        last;
   } telegram_result_type;

   class telegram_scoreboard;
      frame_phase_type     phase;
      logic [7:0]          line_buf[LINE_MAX];
      int                  line_len;
      int                  open_at;
      int                  close_at;
      int                  star_at;
      bit                  line_ovf;
      logic [15:0]         cks_acc;
      int                  cks_digits;
      telegram_result_type expected_results[$];
      int                  n_errors;
      int                  n_used;

      function new();
         phase      = PH_IDLE;
         cks_acc    = '0;
         cks_digits = 0;
         n_errors   = 0;
         n_used     = 0;
         clear_line();
      endfunction

      function void report(string msg);
         n_errors++;
         if (n_errors <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
      endfunction

      static function int hex_digit(logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c - "0");
         if (c >= "a" && c <= "f") return int'(c - "a") + 10;
         if (c >= "A" && c <= "F") return int'(c - "A") + 10;
         return -1;
      endfunction

      static function bit is_eol(logic [7:0] c);
         return c == CHAR_CR || c == CHAR_LF;
      endfunction

      function void clear_line();
         line_len = 0;
         open_at  = -1;
         close_at = -1;
         star_at  = -1;
         line_ovf = 1'b0;
      endfunction

      function void push(logic [2:0] kind, logic [15:0] payload);
         telegram_result_type r;
         r.kind    = kind;
         r.payload = payload;
         r.last    = 1'b0;
         expected_results.insert(expected_results.size(), r);
      endfunction

      function void push_span(logic [2:0] kind, int from, int upto);
         for (int i = from; i < upto && i < LINE_MAX; i++) begin
            push(kind, {8'h00, line_buf[i]});
         end
      endfunction

      function void store_char(logic [7:0] c);
         if (line_len >= LINE_MAX) begin
            line_ovf = 1'b1;
            return;
         end
         line_buf[line_len] = c;
         if (c == CHAR_OPEN && open_at < 0) begin
            open_at = line_len;
         end else if (c == CHAR_CLOSE && close_at < 0) begin
            close_at = line_len;
         end else if (c == CHAR_STAR && open_at >= 0 && star_at < 0) begin
            star_at = line_len;
         end
         line_len++;
      endfunction

      function void close_register_line();
         int value_end;
         if (line_ovf) begin
            push(KIND_OVERFLOW, '0);
            return;
         end
         if (open_at < 1 || close_at < 0 || open_at > close_at || line_len == 0 ||
             close_at != line_len - 1) begin
            return;
         end
         value_end = (star_at >= 0) ? star_at : close_at;
         push_span(KIND_ID, 0, open_at);
         push_span(KIND_VALUE, open_at + 1, value_end);
         if (star_at >= 0) begin
            push_span(KIND_UNIT, star_at + 1, close_at);
         end
      endfunction

      function void note_byte(logic [7:0] c);
         int first;
         int d;
         first = expected_results.size();
         if (phase != PH_IDLE || c == CHAR_SLASH) begin
            n_used++;
         end
         case (phase)
            PH_HDR: begin
               if (is_eol(c)) begin
                  push(KIND_START, '0);
                  if (line_ovf) push(KIND_OVERFLOW, '0);
                  else push_span(KIND_HEADER, 0, line_len);
                  clear_line();
                  phase = PH_GAP;
               end else begin
                  store_char(c);
               end
            end
            PH_GAP: begin
               if (c == CHAR_BANG) begin
                  cks_acc    = '0;
                  cks_digits = 0;
                  phase      = PH_CKS;
               end else if (!is_eol(c)) begin
                  clear_line();
                  store_char(c);
                  phase = PH_LINE;
               end
            end
            PH_LINE: begin
               if (is_eol(c)) begin
                  close_register_line();
                  clear_line();
                  phase = PH_GAP;
               end else begin
                  store_char(c);
               end
            end
            PH_CKS: begin
               d = hex_digit(c);
               if (d < 0) begin
                  phase = PH_IDLE;
               end else begin
                  cks_acc    = {cks_acc[11:0], 4'(d)};
                  cks_digits = (cks_digits + 1) & 7;
                  if (cks_digits >= CKS_DIGITS) begin
                     push(KIND_END, cks_acc);
                     phase = PH_IDLE;
                  end
               end
            end
            default: begin
               if (c == CHAR_SLASH) begin
                  clear_line();
                  phase = PH_HDR;
               end else begin
                  phase = PH_IDLE;
               end
            end
         endcase
         if (expected_results.size() > first) begin
            expected_results[expected_results.size() - 1].last = 1'b1;
         end
      endfunction

      function void check_result(logic [2:0] kind, logic [15:0] payload, logic last);
         telegram_result_type w;
         if (expected_results.size() == 0) begin
            report($sformatf("unexpected result kind %0d payload %h", kind, payload));
            return;
         end
         w = expected_results.pop_front();
         if (kind !== w.kind) begin
            report($sformatf("kind %0d, want %0d", kind, w.kind));
         end
         if (payload !== w.payload) begin
            report($sformatf("payload %h, want %h (kind %0d)", payload, w.payload, w.kind));
         end
         if (last !== w.last) begin
            report($sformatf("last_of_run %b, want %b (kind %0d)", last, w.last, w.kind));
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void check_drained();
         if (expected_results.size() != 0) begin
            report($sformatf("%0d results never arrived", expected_results.size()));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [15:0] rsp_payload;
   logic        rsp_last_of_run;

   telegram_scoreboard sb = new();
   bit calm = 1'b0;
   bit hold_request = 1'b0;
   int cycle_count = 0;

   meter_telegram_parser_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_payload     (rsp_payload),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // one byte transfer, with an occasional idle gap ahead of it
   task automatic send_byte(logic [7:0] c);
      if (!calm && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= c;
      do @(posedge clock); while (req_stall);
      sb.note_byte(c);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(33, 126));
      while (c == CHAR_OPEN || c == CHAR_CLOSE || c == CHAR_STAR || c == CHAR_BANG);
      return c;
   endfunction

   function automatic logic [7:0] value_char();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return CHAR_OPEN;
      if (r == 1) return CHAR_STAR;
      return plain_char();
   endfunction

   function automatic logic [7:0] any_non_eol();
      logic [7:0] c;
      do c = 8'($urandom); while (telegram_scoreboard::is_eol(c));
      return c;
   endfunction

   task automatic send_line_end();
      case ($urandom_range(0, 3))
         0: send_byte(CHAR_CR);
         1: send_byte(CHAR_LF);
         2: begin
            send_byte(CHAR_CR);
            send_byte(CHAR_LF);
         end
         default: begin
            send_byte(CHAR_LF);
            send_byte(CHAR_LF);
         end
      endcase
   endtask

   task automatic send_register_line();
      int shape;
      int id_n;
      int val_n;
      int unit_n;
      int n;
      bit with_unit;
      logic [7:0] c;
      shape = $urandom_range(0, 9);
      if (shape <= 6) begin
         id_n      = $urandom_range(1, 4);
         val_n     = $urandom_range(0, 6);
         with_unit = 1'($urandom_range(0, 1));
         unit_n    = $urandom_range(0, 3);
         if (shape == 6) begin
            // near or past the line buffer size
            with_unit = 1'b0;
            id_n      = $urandom_range(1, 3);
            val_n     = $urandom_range(30, 36) - id_n - 2;
         end
         repeat (id_n) send_byte(plain_char());
         send_byte(CHAR_OPEN);
         repeat (val_n) send_byte(value_char());
         if (with_unit) begin
            send_byte(CHAR_STAR);
            repeat (unit_n) send_byte(value_char());
         end
         send_byte(CHAR_CLOSE);
      end else if (shape <= 8) begin
         n = $urandom_range(1, 10);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
               0: send_byte(CHAR_OPEN);
               1: send_byte(CHAR_CLOSE);
               2: send_byte(CHAR_STAR);
               default: send_byte(plain_char());
            endcase
         end
      end else begin
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) begin
            do c = any_non_eol(); while (i == 0 && c == CHAR_BANG);
            send_byte(c);
         end
      end
      send_line_end();
   endtask

   task automatic send_checksum();
      int bad_at;
      int v;
      logic [7:0] c;
      send_byte(CHAR_BANG);
      bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : CKS_DIGITS;
      for (int i = 0; i < CKS_DIGITS; i++) begin
         if (i == bad_at) begin
            if ($urandom_range(0, 2) == 0) begin
               c = CHAR_SLASH;
            end else begin
               do c = 8'($urandom); while (telegram_scoreboard::hex_digit(c) >= 0);
            end
            send_byte(c);
            return;
         end
         v = $urandom_range(0, 15);
         if (v < 10) c = 8'("0" + v);
         else if ($urandom_range(0, 1) == 1) c = 8'("A" + v - 10);
         else c = 8'("a" + v - 10);
         send_byte(c);
      end
   endtask

   task automatic send_telegram();
      int r;
      int hdr_n;
      if ($urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
      send_byte(CHAR_SLASH);
      r = $urandom_range(0, 9);
      hdr_n = (r == 0) ? 0 : (r == 1) ? $urandom_range(28, 36) : $urandom_range(1, 10);
      repeat (hdr_n) send_byte(any_non_eol());
      send_line_end();
      repeat ($urandom_range(0, 4)) send_register_line();
      if ($urandom_range(0, 9) != 0) begin
         send_checksum();
      end
   endtask

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            sb.check_result(rsp_kind, rsp_payload, rsp_last_of_run);
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 13);
         end
      end
   end

   initial begin : stimulus
      int base;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // bytes outside a frame, empty header, empty line, split unit,
      // bad checksum digit that swallows a slash, line with '(' first
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("x/");
      send_byte(CHAR_CR);
      send_text("\n1(2*k)\n!aF/");
      send_text("/A\n(1)\n!FFFF");

      base = sb.n_used;
      hold_request = 1'b1;
      while (sb.n_used < base + RANDOM_ITEMS) begin
         calm = (sb.n_used >= base + 50) && (sb.n_used < base + 110);
         send_telegram();
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      sb.check_drained();
      if (sb.n_errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/mtp_pkg.sv
hw/rtl/mtp_datapath.sv
hw/rtl/mtp_ctrl.sv
hw/rtl/meter_telegram_parser_top.sv
verif/meter_telegram_parser_top_test.sv
